FILE: design/sls_pkg.sv
// Shared types, constants and helper functions of the script lexical scanner.
package sls_pkg;

  localparam int OFF_BITS = 16;
  typedef logic [OFF_BITS-1:0] off_t;
  localparam off_t OFF_MAX = '1;
  localparam off_t OFF_CLIP = off_t'(17'h0FFFF);

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQ, M_LT, M_GT, M_SLASH, M_LINE,
    M_BLOCK, M_BSTAR, M_STR, M_INT, M_DOT, M_FRAC, M_WORD
  } mode_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_EQ     = 6'd13;
  localparam logic [5:0] K_GT     = 6'd15;
  localparam logic [5:0] K_LT     = 6'd17;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_INT    = 6'd21;
  localparam logic [5:0] K_FLOAT  = 6'd22;
  localparam logic [5:0] K_END    = 6'd39;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_UNTERM  = 2'd2;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  status;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    off_t        bpos;
    off_t        lstart;
    logic [15:0] line;
    logic [47:0] wbytes;
    logic [2:0]  wlen;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{mode: M_IDLE, bpos: '0, lstart: '0,
                                          line: 16'd1, wbytes: '0, wlen: '0};

  // Keyword spellings, first character in the lowest byte.
  localparam logic [47:0] KW_TEXT [16] = '{
    48'h0000_0064_6E61, 48'h0073_7361_6C63, 48'h0000_6573_6C65, 48'h0065_736C_6166,
    48'h0000_0072_6F66, 48'h0000_006E_7566, 48'h0000_0000_6669, 48'h0000_006C_696E,
    48'h0000_0000_726F, 48'h0074_6E69_7270, 48'h6E72_7574_6572, 48'h0072_6570_7573,
    48'h0000_7369_6874, 48'h0000_6575_7274, 48'h0000_0072_6176, 48'h0065_6C69_6877
  };
  localparam logic [2:0] KW_LEN [16] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };
  localparam logic [5:0] KW_BASE = 6'd23;

  function automatic logic [15:0] clip16(off_t v);
    return (v > OFF_CLIP) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic off_t span(off_t a, off_t b);
    return (b > a) ? off_t'(b - a) : '0;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [5:0] word_kind(logic [47:0] wb, logic [2:0] wl);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if ((wl == KW_LEN[i]) && (wb == KW_TEXT[i])) k = KW_BASE + 6'(i);
    end
    return k;
  endfunction

  function automatic result_t make_res(logic [5:0] kind, logic [1:0] status, off_t start,
                                       off_t len, logic [15:0] line);
    result_t r;
    r.kind   = kind;
    r.status = status;
    r.start  = clip16(start);
    r.len    = clip16(len);
    r.line   = line;
    return r;
  endfunction

endpackage

FILE: design/sls_step.sv
// Combinational next-state and token logic for one source byte.
module sls_step (
  input  sls_pkg::scan_state_t cur,
  input  logic [7:0]           ch,
  input  logic                 last,
  output sls_pkg::scan_state_t nxt_state,
  output sls_pkg::result_t     res [sls_pkg::MAX_RES],
  output logic [2:0]           res_count
);

  typedef struct packed {
    logic             v0;
    logic             v1;
    sls_pkg::result_t r0;
    sls_pkg::result_t r1;
  } flush_t;

  // Pending token of a mode, given the offset just past its last byte.
  function automatic flush_t flush(sls_pkg::mode_t m, sls_pkg::off_t ls, sls_pkg::off_t e,
                                   logic [5:0] wk, logic [15:0] ln);
    flush_t f;
    sls_pkg::off_t d;
    f = '0;
    d = (e != '0) ? sls_pkg::off_t'(e - 1'b1) : '0;
    unique case (m)
      sls_pkg::M_BANG: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_BANG, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_EQ: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_EQ, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_LT: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_LT, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_GT: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_GT, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_SLASH: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_SLASH, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_STR: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(6'd0, sls_pkg::ST_UNTERM, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_INT: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_INT, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_DOT: begin
        f.v0 = 1'b1;
        f.v1 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_INT, sls_pkg::ST_OK, ls, sls_pkg::span(ls, d), ln);
        f.r1 = sls_pkg::make_res(sls_pkg::K_DOT, sls_pkg::ST_OK, d, sls_pkg::off_t'(1), ln);
      end
      sls_pkg::M_FRAC: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(sls_pkg::K_FLOAT, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      sls_pkg::M_WORD: begin f.v0 = 1'b1;
        f.r0 = sls_pkg::make_res(wk, sls_pkg::ST_OK, ls, sls_pkg::span(ls, e), ln);
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] ln);
    return (ln != 16'hFFFF) ? ln + 16'd1 : ln;
  endfunction

  sls_pkg::off_t    pos, nxt;
  logic             done;
  sls_pkg::mode_t   m2;
  sls_pkg::off_t    ls2;
  logic [15:0]      ln2;
  logic [47:0]      wb2;
  logic [2:0]       wl2;
  logic             vc;
  sls_pkg::result_t rc;
  flush_t           fa, fd;
  sls_pkg::result_t cand [6];
  logic [5:0]       cv;
  logic [2:0]       n;

  always_comb begin
    pos  = cur.bpos;
    nxt  = (pos == sls_pkg::OFF_MAX) ? pos : sls_pkg::off_t'(pos + 1'b1);
    done = 1'b0;
    m2   = cur.mode;
    ls2  = cur.lstart;
    ln2  = cur.line;
    wb2  = cur.wbytes;
    wl2  = cur.wlen;
    vc   = 1'b0;
    rc   = '0;

    // Bytes that continue the pending lexeme.
    unique case (cur.mode) inside
      sls_pkg::M_BANG, sls_pkg::M_EQ, sls_pkg::M_LT, sls_pkg::M_GT: begin
        if (ch == "=") begin
          vc   = 1'b1;
          done = 1'b1;
          m2   = sls_pkg::M_IDLE;
          rc   = sls_pkg::make_res(6'((cur.mode == sls_pkg::M_BANG) ? sls_pkg::K_BANG + 6'd1 :
                                      (cur.mode == sls_pkg::M_EQ)   ? sls_pkg::K_EQ + 6'd1 :
                                      (cur.mode == sls_pkg::M_LT)   ? sls_pkg::K_LT + 6'd1 :
                                                                      sls_pkg::K_GT + 6'd1),
                                   sls_pkg::ST_OK, cur.lstart, sls_pkg::span(cur.lstart, nxt),
                                   cur.line);
        end
      end
      sls_pkg::M_SLASH: begin
        if (ch == "/") begin m2 = sls_pkg::M_LINE; done = 1'b1; end
        else if (ch == "*") begin m2 = sls_pkg::M_BLOCK; done = 1'b1; end
      end
      sls_pkg::M_LINE: begin
        if (ch != sls_pkg::CH_LF) done = 1'b1;
      end
      sls_pkg::M_BLOCK: begin
        done = 1'b1;
        if (ch == "*") m2 = sls_pkg::M_BSTAR;
        else if (ch == sls_pkg::CH_LF) ln2 = bump(cur.line);
      end
      sls_pkg::M_BSTAR: begin
        done = 1'b1;
        if (ch == "/") m2 = sls_pkg::M_IDLE;
        else if (ch != "*") begin
          if (ch == sls_pkg::CH_LF) ln2 = bump(cur.line);
          m2 = sls_pkg::M_BLOCK;
        end
      end
      sls_pkg::M_STR: begin
        done = 1'b1;
        if (ch == "\"") begin
          vc = 1'b1;
          m2 = sls_pkg::M_IDLE;
          rc = sls_pkg::make_res(sls_pkg::K_STRING, sls_pkg::ST_OK, cur.lstart,
                                 sls_pkg::span(cur.lstart, nxt), cur.line);
        end else if (ch == sls_pkg::CH_LF) begin
          ln2 = bump(cur.line);
        end
      end
      sls_pkg::M_INT: begin
        if (sls_pkg::is_digit(ch)) done = 1'b1;
        else if (ch == ".") begin m2 = sls_pkg::M_DOT; done = 1'b1; end
      end
      sls_pkg::M_DOT: begin
        if (sls_pkg::is_digit(ch)) begin m2 = sls_pkg::M_FRAC; done = 1'b1; end
      end
      sls_pkg::M_FRAC: begin
        if (sls_pkg::is_digit(ch)) done = 1'b1;
      end
      sls_pkg::M_WORD: begin
        if (sls_pkg::is_alpha(ch) || sls_pkg::is_digit(ch)) begin
          done = 1'b1;
          if (cur.wlen < 3'd6) begin
            for (int i = 0; i < 6; i++) begin
              if (cur.wlen == 3'(i)) wb2[8*i +: 8] = ch;
            end
            wl2 = cur.wlen + 3'd1;
          end else begin
            wl2 = 3'd7;
          end
        end
      end
      default: m2 = sls_pkg::M_IDLE;
    endcase

    fa = '0;
    if (!done) begin
      fa  = flush(cur.mode, cur.lstart, pos, sls_pkg::word_kind(cur.wbytes, cur.wlen), cur.line);
      m2  = sls_pkg::M_IDLE;
      ls2 = pos;
      vc  = 1'b1;
      case (ch) inside
        "(": rc = sls_pkg::make_res(sls_pkg::K_LPAREN, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        ")": rc = sls_pkg::make_res(sls_pkg::K_RPAREN, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "{": rc = sls_pkg::make_res(sls_pkg::K_LBRACE, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "}": rc = sls_pkg::make_res(sls_pkg::K_RBRACE, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        ",": rc = sls_pkg::make_res(sls_pkg::K_COMMA, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        ".": rc = sls_pkg::make_res(sls_pkg::K_DOT, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "-": rc = sls_pkg::make_res(sls_pkg::K_MINUS, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "+": rc = sls_pkg::make_res(sls_pkg::K_PLUS, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        ";": rc = sls_pkg::make_res(sls_pkg::K_SEMI, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "*": rc = sls_pkg::make_res(sls_pkg::K_STAR, sls_pkg::ST_OK, pos,
                                    sls_pkg::off_t'(1), cur.line);
        "!": begin vc = 1'b0; m2 = sls_pkg::M_BANG; end
        "=": begin vc = 1'b0; m2 = sls_pkg::M_EQ; end
        "<": begin vc = 1'b0; m2 = sls_pkg::M_LT; end
        ">": begin vc = 1'b0; m2 = sls_pkg::M_GT; end
        "/": begin vc = 1'b0; m2 = sls_pkg::M_SLASH; end
        "\"": begin vc = 1'b0; m2 = sls_pkg::M_STR; end
        " ", sls_pkg::CH_CR, sls_pkg::CH_TAB: vc = 1'b0;
        sls_pkg::CH_LF: begin vc = 1'b0; ln2 = bump(cur.line); end
        default: begin
          if (sls_pkg::is_digit(ch)) begin
            vc = 1'b0;
            m2 = sls_pkg::M_INT;
          end else if (sls_pkg::is_alpha(ch)) begin
            vc  = 1'b0;
            m2  = sls_pkg::M_WORD;
            wb2 = {40'd0, ch};
            wl2 = 3'd1;
          end else begin
            rc = sls_pkg::make_res(6'd0, sls_pkg::ST_BADCHAR, pos, sls_pkg::off_t'(1),
                                   cur.line);
          end
        end
      endcase
    end

    fd = '0;
    if (last) begin
      fd        = flush(m2, ls2, nxt, sls_pkg::word_kind(wb2, wl2), ln2);
      nxt_state = sls_pkg::SCAN_RESET;
    end else begin
      nxt_state = '{mode: m2, bpos: nxt, lstart: ls2, line: ln2, wbytes: wb2, wlen: wl2};
    end

    cand[0] = fa.r0;
    cand[1] = fa.r1;
    cand[2] = rc;
    cand[3] = fd.r0;
    cand[4] = fd.r1;
    cand[5] = sls_pkg::make_res(sls_pkg::K_END, sls_pkg::ST_OK, nxt, '0, ln2);
    cv = {last, fd.v1, fd.v0, vc, fa.v1, fa.v0};

    // Pack the produced tokens in order; anything past the fourth is dropped.
    for (int i = 0; i < sls_pkg::MAX_RES; i++) res[i] = '0;
    n = '0;
    for (int i = 0; i < 6; i++) begin
      if (cv[i] && (n < 3'(sls_pkg::MAX_RES))) begin
        res[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    res_count = n;
  end

endmodule

FILE: design/script_lexical_scanner_top.sv
// Top level of the script lexical scanner: state registers and token buffer.
//
// Source bytes enter on the s_ channel, one byte per beat, with s_tlast on the
// final byte of a source. Tokens leave on the m_ channel, one per beat: kind
// and status in m_tuser, offset, length and line in m_tdata, and m_tlast on
// the last token that a byte produced. A byte gives zero to four tokens.
// The byte is scanned in the cycle it is accepted and its tokens are loaded
// into a four-entry buffer, so the first token is offered in the next cycle.
// A new byte is taken when the buffer is empty or its final token is leaving
// in that cycle, so a byte that yields at most one token sustains one byte
// per cycle while the receiver does not stall; a byte with several tokens
// holds the input until its last token leaves through the single output port.
// On a receiver stall the buffer holds; s_tready is low while it is not empty.
// After the final byte of a source the end token is emitted and the scanner
// returns to its reset state, ready for the next source. Reset is
// synchronous: it empties the buffer and restores line 1, offset 0.
module script_lexical_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] start_offset, [31:16] lexeme_length, [47:32] line
  output logic [7:0]  m_tuser,   // [5:0] token_kind, [7:6] status
  output logic        m_tlast
);

  sls_pkg::scan_state_t state, state_next;
  sls_pkg::result_t     step_res [sls_pkg::MAX_RES];
  logic [2:0]           step_count;
  sls_pkg::result_t     tok [sls_pkg::MAX_RES];
  logic [2:0]           cnt;
  logic                 accept, pop;

  sls_step u_step (
    .cur       (state),
    .ch        (s_tdata),
    .last      (s_tlast),
    .nxt_state (state_next),
    .res       (step_res),
    .res_count (step_count)
  );

  assign m_tvalid = (cnt != 3'd0);
  assign s_tready = (cnt == 3'd0) || ((cnt == 3'd1) && m_tready);
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sls_pkg::SCAN_RESET;
      cnt   <= 3'd0;
    end else begin
      if (accept) begin
        state <= state_next;
        cnt   <= step_count;
      end else if (pop) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok <= step_res;
    end else if (pop) begin
      for (int i = 0; i < sls_pkg::MAX_RES - 1; i++) tok[i] <= tok[i+1];
    end
  end

  assign m_tdata = {tok[0].line, tok[0].len, tok[0].start};
  assign m_tuser = {tok[0].status, tok[0].kind};
  assign m_tlast = (cnt == 3'd1);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(sls_pkg::MAX_RES))
    else $error("token buffer count out of range");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (cnt != 3'd0) && (tok[0].kind != sls_pkg::K_END || cnt == 3'd1))
    else $error("final byte produced no tokens or end token not last");

  a_source_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (state.bpos == '0) && (state.line == 16'd1)
                            && (state.mode == sls_pkg::M_IDLE))
    else $error("scanner state not restored after final byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.line != 16'd0)
    else $error("line counter reached zero");

endmodule

FILE: tb/tb_script_lexical_scanner_top.sv
// Self-checking testbench of the script lexical scanner: byte stimulus, token prediction, checks.
module tb_script_lexical_scanner_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [7:0]  m_tuser;
  logic        m_tlast;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  status;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        tail;
  } token_t;

  token_t      token_queue[$];
  int          errors = 0;
  int          n_bytes = 0;
  int          n_tokens = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  // Predictor state.
  sls_pkg::mode_t p_mode;
  logic [31:0] p_pos;
  logic [31:0] p_lstart;
  logic [15:0] p_line;
  logic [47:0] p_wbytes;
  logic [2:0]  p_wlen;
  token_t      step_toks[$];

  script_lexical_scanner_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("script_lexical_scanner_top: mismatch");
    $finish;
  end

  function automatic logic [15:0] sat16(logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [31:0] dist16(logic [31:0] a, logic [31:0] b);
    return (b > a) ? b - a : 32'd0;
  endfunction

  function automatic logic digit_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  task automatic scan_reset();
    p_mode = sls_pkg::M_IDLE;
    p_pos = 0;
    p_lstart = 0;
    p_line = 16'd1;
    p_wbytes = '0;
    p_wlen = '0;
  endtask

  task automatic push_tok(logic [5:0] k, logic [1:0] s, logic [31:0] st, logic [31:0] ln);
    token_t t;
    if (step_toks.size() < sls_pkg::MAX_RES) begin
      t.kind = k;
      t.status = s;
      t.start = sat16(st);
      t.len = sat16(ln);
      t.line = p_line;
      t.tail = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endtask

  task automatic next_line();
    if (p_line < 16'hFFFF) p_line++;
  endtask

  task automatic add_letter(logic [7:0] c);
    if (p_wlen < 6) begin
      p_wbytes = p_wbytes | (48'(c) << (8 * p_wlen));
      p_wlen++;
    end else begin
      p_wlen = 3'd7;
    end
  endtask

  function automatic logic [5:0] keyword_of(logic [47:0] wb, logic [2:0] wl);
    string names[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                         "or", "print", "return", "super", "this", "true", "var", "while"};
    logic [47:0] packed_name;
    for (int i = 0; i < 16; i++) begin
      packed_name = '0;
      for (int j = 0; j < names[i].len(); j++)
        packed_name |= 48'(names[i][j]) << (8 * j);
      if (wl == names[i].len() && wb == packed_name) return sls_pkg::KW_BASE + 6'(i);
    end
    return sls_pkg::K_IDENT;
  endfunction

  function automatic logic [5:0] op_kind(sls_pkg::mode_t m);
    case (m)
      sls_pkg::M_BANG: return sls_pkg::K_BANG;
      sls_pkg::M_EQ:   return sls_pkg::K_EQ;
      sls_pkg::M_LT:   return sls_pkg::K_LT;
      default:         return sls_pkg::K_GT;
    endcase
  endfunction

  task automatic flush_pending(logic [31:0] stop);
    logic [31:0] d;
    case (p_mode)
      sls_pkg::M_BANG, sls_pkg::M_EQ, sls_pkg::M_LT, sls_pkg::M_GT:
        push_tok(op_kind(p_mode), sls_pkg::ST_OK, p_lstart, dist16(p_lstart, stop));
      sls_pkg::M_SLASH:
        push_tok(sls_pkg::K_SLASH, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, stop));
      sls_pkg::M_STR:
        push_tok(6'd0, sls_pkg::ST_UNTERM, p_lstart, dist16(p_lstart, stop));
      sls_pkg::M_INT:
        push_tok(sls_pkg::K_INT, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, stop));
      sls_pkg::M_DOT: begin
        d = stop > 0 ? stop - 1 : 0;
        push_tok(sls_pkg::K_INT, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, d));
        push_tok(sls_pkg::K_DOT, sls_pkg::ST_OK, d, 1);
      end
      sls_pkg::M_FRAC:
        push_tok(sls_pkg::K_FLOAT, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, stop));
      sls_pkg::M_WORD:
        push_tok(keyword_of(p_wbytes, p_wlen), sls_pkg::ST_OK, p_lstart,
                 dist16(p_lstart, stop));
      default: ;
    endcase
    p_mode = sls_pkg::M_IDLE;
  endtask

  task automatic start_lexeme(logic [7:0] c, logic [31:0] pos);
    p_lstart = pos;
    case (c)
      "(": push_tok(sls_pkg::K_LPAREN, sls_pkg::ST_OK, pos, 1);
      ")": push_tok(sls_pkg::K_RPAREN, sls_pkg::ST_OK, pos, 1);
      "{": push_tok(sls_pkg::K_LBRACE, sls_pkg::ST_OK, pos, 1);
      "}": push_tok(sls_pkg::K_RBRACE, sls_pkg::ST_OK, pos, 1);
      ",": push_tok(sls_pkg::K_COMMA, sls_pkg::ST_OK, pos, 1);
      ".": push_tok(sls_pkg::K_DOT, sls_pkg::ST_OK, pos, 1);
      "-": push_tok(sls_pkg::K_MINUS, sls_pkg::ST_OK, pos, 1);
      "+": push_tok(sls_pkg::K_PLUS, sls_pkg::ST_OK, pos, 1);
      ";": push_tok(sls_pkg::K_SEMI, sls_pkg::ST_OK, pos, 1);
      "*": push_tok(sls_pkg::K_STAR, sls_pkg::ST_OK, pos, 1);
      "!": p_mode = sls_pkg::M_BANG;
      "=": p_mode = sls_pkg::M_EQ;
      "<": p_mode = sls_pkg::M_LT;
      ">": p_mode = sls_pkg::M_GT;
      "/": p_mode = sls_pkg::M_SLASH;
      8'h22: p_mode = sls_pkg::M_STR;
      " ", sls_pkg::CH_CR, sls_pkg::CH_TAB: ;
      sls_pkg::CH_LF: next_line();
      default: begin
        if (digit_ch(c)) begin
          p_mode = sls_pkg::M_INT;
        end else if (letter_ch(c)) begin
          p_mode = sls_pkg::M_WORD;
          p_wbytes = '0;
          p_wlen = '0;
          add_letter(c);
        end else begin
          push_tok(6'd0, sls_pkg::ST_BADCHAR, pos, 1);
        end
      end
    endcase
  endtask

  // Works out the tokens of one byte and appends them to token_queue.
  task automatic predict_tokens(logic [7:0] c, logic lst);
    logic [31:0] pos, nxt;
    logic taken;
    step_toks.delete();
    pos = p_pos > 32'hFFFF ? 32'hFFFF : p_pos;
    nxt = pos < 32'hFFFF ? pos + 1 : 32'hFFFF;
    taken = 1'b0;
    case (p_mode)
      sls_pkg::M_BANG, sls_pkg::M_EQ, sls_pkg::M_LT, sls_pkg::M_GT:
        if (c == "=") begin
          push_tok(op_kind(p_mode) + 6'd1, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, nxt));
          p_mode = sls_pkg::M_IDLE;
          taken = 1'b1;
        end
      sls_pkg::M_SLASH:
        if (c == "/") begin
          p_mode = sls_pkg::M_LINE;
          taken = 1'b1;
        end else if (c == "*") begin
          p_mode = sls_pkg::M_BLOCK;
          taken = 1'b1;
        end
      sls_pkg::M_LINE: if (c != sls_pkg::CH_LF) taken = 1'b1;
      sls_pkg::M_BLOCK: begin
        taken = 1'b1;
        if (c == "*") p_mode = sls_pkg::M_BSTAR;
        else if (c == sls_pkg::CH_LF) next_line();
      end
      sls_pkg::M_BSTAR: begin
        taken = 1'b1;
        if (c == "/") begin
          p_mode = sls_pkg::M_IDLE;
        end else if (c != "*") begin
          if (c == sls_pkg::CH_LF) next_line();
          p_mode = sls_pkg::M_BLOCK;
        end
      end
      sls_pkg::M_STR: begin
        taken = 1'b1;
        if (c == 8'h22) begin
          push_tok(sls_pkg::K_STRING, sls_pkg::ST_OK, p_lstart, dist16(p_lstart, nxt));
          p_mode = sls_pkg::M_IDLE;
        end else if (c == sls_pkg::CH_LF) begin
          next_line();
        end
      end
      sls_pkg::M_INT:
        if (digit_ch(c)) begin
          taken = 1'b1;
        end else if (c == ".") begin
          p_mode = sls_pkg::M_DOT;
          taken = 1'b1;
        end
      sls_pkg::M_DOT:
        if (digit_ch(c)) begin
          p_mode = sls_pkg::M_FRAC;
          taken = 1'b1;
        end
      sls_pkg::M_FRAC: if (digit_ch(c)) taken = 1'b1;
      sls_pkg::M_WORD:
        if (letter_ch(c) || digit_ch(c)) begin
          add_letter(c);
          taken = 1'b1;
        end
      default: p_mode = sls_pkg::M_IDLE;
    endcase
    if (!taken) begin
      flush_pending(pos);
      start_lexeme(c, pos);
    end
    p_pos = nxt;
    if (lst) begin
      flush_pending(nxt);
      push_tok(sls_pkg::K_END, sls_pkg::ST_OK, nxt, 0);
      scan_reset();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].tail = 1'b1;
    token_queue = {token_queue, step_toks};
  endtask

  // Sends one byte; the prediction is made when the beat is accepted.
  // tvalid stays high after a beat unless the sender idles or the test drains.
  task automatic send_byte(logic [7:0] c, logic lst);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tokens(c, lst);
    n_bytes++;
  endtask

  task automatic send_text(string s, logic close_source);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_source && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (token_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    token_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[5:0], m_tuser[7:6], m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
             m_tlast};
      n_tokens++;
      if (token_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, actual %h", $time, got);
      end else begin
        want = token_queue.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.start !== want.start || got.len !== want.len ||
            got.line !== want.line || got.tail !== want.tail) begin
          errors++;
          $display("%0t: token mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_text("(){},.-+;*/", 1'b0);
    send_text("!!= = ==<<=>>=", 1'b0);
    send_text("\"a\nb\" 1 3.5 7.x 9.", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_keywords();
    send_text("if else return _x9 returnx//c\n", 1'b0);
    send_text("/*\n**/x/*", 1'b1);
    send_text("\"o", 1'b1);
    send_text("5.", 1'b1);
  endtask

  function automatic logic [7:0] pick_char();
    string alphabet = "()+-*/.;,!=<>\"\n \t\r_aAzZ0912.efilnorstuwhv";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  task automatic test_random(int n);
    string pieces[12] = '{"if ", "while(", "x1 ", "42", "3.14", "\"s t\"", "// c\n",
                          "/* k*/", "<=", "!=", "\n", "return;"};
    int sent;
    string p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(2) != 0) begin
        p = pieces[$urandom_range(11)];
        send_text(p, 1'b0);
        sent += p.len();
      end else begin
        send_byte(pick_char(), $urandom_range(15) == 0);
        sent++;
      end
      if ($urandom_range(40) == 0) wait_drained();
    end
    send_byte(";", 1'b1);
  endtask

  initial begin
    scan_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 17;
    recv_idle = 85;
    test_directed();
    test_random(5);
    wait_drained();
    send_idle = 85;
    recv_idle = 17;
    test_keywords();
    test_random(5);
    send_idle = 0;
    recv_idle = 0;
    test_random(5);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes (operators, literals, keywords, comments, bad characters),",
             n_bytes);
    $display("checked %0d tokens under several stall patterns.", n_tokens);
    if (errors == 0 && token_queue.size() == 0) begin
      $display("script_lexical_scanner_top: match");
    end else begin
      $display("script_lexical_scanner_top: mismatch");
    end
    $finish;
  end
endmodule
